// ===== design/tlps_pkg.sv =====
package tlps_pkg;

   localparam int NUM_PROCS = 16;
   localparam int IDX_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int CNT_W     = $clog2(NUM_PROCS + 1);
   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int TIME_W    = 21;
   localparam int PIDX_W    = 4;

   localparam logic CLASS_SYSTEM = 1'b0;
   localparam logic CLASS_USER   = 1'b1;

   typedef struct packed {
      logic [ARR_W-1:0]   arrival_time;
      logic [BURST_W-1:0] burst_time;
      logic               process_class;
      logic               last_process;
   } req_type;

   typedef struct packed {
      logic [PIDX_W-1:0] process_index;
      logic [TIME_W-1:0] completion_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [TIME_W-1:0] waiting_time;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic               pclass;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic load;        // store an accepted record
      logic scan_clear;  // restart the table scan and drop the candidates
      logic scan;        // step the table scan
      logic decide;      // commit the pick or jump the clock
      logic out_sel;     // point the table reads at the result index
      logic out_load;    // capture one result into the output register
      logic out_next;    // advance to the next result
      logic run_clear;   // return the run state to its reset values
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic last_pick;
      logic out_last;
   } status_type;

endpackage

// ===== design/tlps_ram.sv =====
module tlps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tlps_ctrl.sv =====
module tlps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tlps_pkg::status_type  status,
   output tlps_pkg::cmd_type     cmd
);

   typedef enum logic [5:0] {
      S_LOAD     = 6'b000001,
      S_SCAN     = 6'b000010,
      S_DECIDE   = 6'b000100,
      S_OUT_RD   = 6'b001000,
      S_OUT_LD   = 6'b010000,
      S_OUT_WAIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide     = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in       = status.last_pick ? S_OUT_RD : S_SCAN;
         end
         S_OUT_RD: begin
            cmd.out_sel = 1'b1;
            state_in    = S_OUT_LD;
         end
         S_OUT_LD: begin
            cmd.out_sel  = 1'b1;
            cmd.out_load = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            rsp_valid   = 1'b1;
            cmd.out_sel = 1'b1;
            if (rsp_ready) begin
               cmd.out_next = 1'b1;
               if (status.out_last) begin
                  cmd.run_clear = 1'b1;
                  state_in      = S_LOAD;
               end else begin
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

// ===== design/tlps_dp.sv =====
module tlps_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  tlps_pkg::cmd_type     cmd,
   input  tlps_pkg::req_type     req_data,
   output tlps_pkg::status_type  status,
   output tlps_pkg::rsp_type     rsp_data
);

   localparam int IDX_W  = tlps_pkg::IDX_W;
   localparam int CNT_W  = tlps_pkg::CNT_W;
   localparam int TIME_W = tlps_pkg::TIME_W;
   localparam int ARR_W  = tlps_pkg::ARR_W;
   localparam int BURST_W = tlps_pkg::BURST_W;
   localparam int PIDX_W = tlps_pkg::PIDX_W;
   localparam int NP     = tlps_pkg::NUM_PROCS;

   // run state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  done_ff, done_in;
   logic [TIME_W-1:0] clock_ff, clock_in;
   logic [NP-1:0]     fin_ff, fin_in;

   // scan state
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;

   // candidates
   logic               sys_found_ff, sys_found_in;
   logic [ARR_W-1:0]   sys_arr_ff, sys_arr_in;
   logic [BURST_W-1:0] sys_burst_ff, sys_burst_in;
   logic [IDX_W-1:0]   sys_idx_ff, sys_idx_in;
   logic               usr_found_ff, usr_found_in;
   logic [ARR_W-1:0]   usr_arr_ff, usr_arr_in;
   logic [BURST_W-1:0] usr_burst_ff, usr_burst_in;
   logic [IDX_W-1:0]   usr_idx_ff, usr_idx_in;
   logic               min_found_ff, min_found_in;
   logic [ARR_W-1:0]   min_arr_ff, min_arr_in;

   // results
   logic [CNT_W-1:0]   out_idx_ff, out_idx_in;
   tlps_pkg::rsp_type  rsp_ff, rsp_in;

   // memories
   logic              rec_wr_en;
   tlps_pkg::rec_type rec_wr_data, rec_rd_data;
   logic [IDX_W-1:0]  rec_rd_addr;
   logic              comp_wr_en;
   logic [IDX_W-1:0]  comp_wr_addr;
   logic [TIME_W-1:0] comp_wr_data, comp_rd_data;

   logic               issue_ok;
   logic               ready_now;
   logic               pick_found;
   logic [BURST_W-1:0] pick_burst;
   logic [IDX_W-1:0]   pick_idx;
   logic [TIME_W-1:0]  tat;

   assign issue_ok    = scan_idx_ff < count_ff;
   assign ready_now   = !fin_ff[pend_idx_ff] &&
                        (TIME_W'(rec_rd_data.arrival) <= clock_ff);
   assign pick_found  = sys_found_ff || usr_found_ff;
   assign pick_burst  = sys_found_ff ? sys_burst_ff : usr_burst_ff;
   assign pick_idx    = sys_found_ff ? sys_idx_ff : usr_idx_ff;

   assign rec_wr_en   = cmd.load && (count_ff < CNT_W'(NP));
   assign rec_wr_data = '{arrival: req_data.arrival_time,
                          burst:   req_data.burst_time,
                          pclass:  req_data.process_class};
   assign rec_rd_addr = cmd.out_sel ? out_idx_ff[IDX_W-1:0] : scan_idx_ff[IDX_W-1:0];

   assign comp_wr_en   = cmd.decide && pick_found;
   assign comp_wr_addr = pick_idx;
   assign comp_wr_data = clock_ff + TIME_W'(pick_burst);

   tlps_ram #(.WIDTH(tlps_pkg::REC_W), .DEPTH(NP)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (rec_wr_data),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   tlps_ram #(.WIDTH(TIME_W), .DEPTH(NP)) u_comp_ram (
      .clock   (clock),
      .wr_en   (comp_wr_en),
      .wr_addr (comp_wr_addr),
      .wr_data (comp_wr_data),
      .rd_addr (out_idx_ff[IDX_W-1:0]),
      .rd_data (comp_rd_data)
   );

   assign status.scan_done = !issue_ok && !pend_ff;
   assign status.last_pick = pick_found && ((done_ff + CNT_W'(1)) == count_ff);
   assign status.out_last  = (out_idx_ff + CNT_W'(1)) == count_ff;

   assign tat = comp_rd_data - TIME_W'(rec_rd_data.arrival);

   always_comb begin
      count_in     = count_ff;
      done_in      = done_ff;
      clock_in     = clock_ff;
      fin_in       = fin_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      sys_found_in = sys_found_ff;
      sys_arr_in   = sys_arr_ff;
      sys_burst_in = sys_burst_ff;
      sys_idx_in   = sys_idx_ff;
      usr_found_in = usr_found_ff;
      usr_arr_in   = usr_arr_ff;
      usr_burst_in = usr_burst_ff;
      usr_idx_in   = usr_idx_ff;
      min_found_in = min_found_ff;
      min_arr_in   = min_arr_ff;
      out_idx_in   = out_idx_ff;
      rsp_in       = rsp_ff;

      if (rec_wr_en) begin
         fin_in[count_ff[IDX_W-1:0]] = 1'b0;
         count_in = count_ff + CNT_W'(1);
      end

      // issue one table read a cycle, compare it the cycle after
      if (cmd.scan) begin
         if (issue_ok) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            pend_in     = 1'b1;
            pend_idx_in = scan_idx_ff[IDX_W-1:0];
         end
         if (pend_ff) begin
            if (ready_now && rec_rd_data.pclass == tlps_pkg::CLASS_SYSTEM &&
                (!sys_found_ff || rec_rd_data.arrival < sys_arr_ff)) begin
               sys_found_in = 1'b1;
               sys_arr_in   = rec_rd_data.arrival;
               sys_burst_in = rec_rd_data.burst;
               sys_idx_in   = pend_idx_ff;
            end
            if (ready_now && rec_rd_data.pclass != tlps_pkg::CLASS_SYSTEM &&
                (!usr_found_ff || rec_rd_data.arrival < usr_arr_ff)) begin
               usr_found_in = 1'b1;
               usr_arr_in   = rec_rd_data.arrival;
               usr_burst_in = rec_rd_data.burst;
               usr_idx_in   = pend_idx_ff;
            end
            if (!fin_ff[pend_idx_ff] &&
                (!min_found_ff || rec_rd_data.arrival < min_arr_ff)) begin
               min_found_in = 1'b1;
               min_arr_in   = rec_rd_data.arrival;
            end
         end
      end

      if (cmd.decide) begin
         if (pick_found) begin
            clock_in         = comp_wr_data;
            fin_in[pick_idx] = 1'b1;
            done_in          = done_ff + CNT_W'(1);
         end else begin
            // nothing ready: jump to the next arrival
            clock_in = TIME_W'(min_arr_ff);
         end
      end

      if (cmd.scan_clear) begin
         scan_idx_in  = '0;
         pend_in      = 1'b0;
         sys_found_in = 1'b0;
         usr_found_in = 1'b0;
         min_found_in = 1'b0;
         out_idx_in   = '0;
      end

      if (cmd.out_load) begin
         rsp_in.process_index   = PIDX_W'(out_idx_ff);
         rsp_in.completion_time = comp_rd_data;
         rsp_in.turnaround_time = tat;
         rsp_in.waiting_time    = tat - TIME_W'(rec_rd_data.burst);
         rsp_in.last_result     = status.out_last;
      end

      if (cmd.out_next) begin
         out_idx_in = out_idx_ff + CNT_W'(1);
      end

      if (cmd.run_clear) begin
         count_in = '0;
         done_in  = '0;
         clock_in = '0;
         fin_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         done_ff     <= '0;
         clock_ff    <= '0;
         fin_ff      <= '0;
         scan_idx_ff <= '0;
         pend_ff     <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         count_ff    <= count_in;
         done_ff     <= done_in;
         clock_ff    <= clock_in;
         fin_ff      <= fin_in;
         scan_idx_ff <= scan_idx_in;
         pend_ff     <= pend_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      sys_found_ff <= sys_found_in;
      sys_arr_ff   <= sys_arr_in;
      sys_burst_ff <= sys_burst_in;
      sys_idx_ff   <= sys_idx_in;
      usr_found_ff <= usr_found_in;
      usr_arr_ff   <= usr_arr_in;
      usr_burst_ff <= usr_burst_in;
      usr_idx_ff   <= usr_idx_in;
      min_found_ff <= min_found_in;
      min_arr_ff   <= min_arr_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/two_level_priority_fcfs_scheduler.sv =====
// Two-level priority, non-preemptive FCFS scheduler.
//
// req channel: one process record per transfer (arrival, burst, class).
// Records are taken back to back while loading. Records beyond NUM_PROCS are dropped.
// The transfer with last_process set closes the set and starts the run;
// req_ready stays low until the last result of that run has gone out.
//
// Each scheduling decision scans the record table once through the
// single read port of the record RAM: one read a cycle, a compare behind
// each read and a step to see the scan end, then a decide step that commits
// the pick or, when idle gaps leave nothing ready, jumps the clock so that
// an extra scan follows.
//
// rsp channel: one result per loaded record, in load order, the last one
// flagged by last_result. Each result passes a table read, a result capture
// and the transfer; when the receiver stalls, the block simply holds
// rsp_valid and the payload until the receiver takes the transfer.
//
// Reset: no records, simulation clock zero, all processes unfinished, the
// block ready for the first record. No clearing pass is needed.
module two_level_priority_fcfs_scheduler (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tlps_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tlps_pkg::rsp_type  rsp_data
);

   tlps_pkg::cmd_type    cmd;
   tlps_pkg::status_type status;

   // sequence load, scan, decide and result phases
   tlps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_process),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the tables, the simulation clock and the candidate registers
   tlps_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // never take a record while a result is on offer
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid high together");

   // the final record starts the run: loading stops
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last_process) |=> !req_ready)
      else $error("still loading after the final record");

   // after the last result the block is ready for a new set
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_result) |=> req_ready)
      else $error("not ready after the last result");

   // a decision only follows a finished scan
   a_decide_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> $past(cmd.scan) && $past(status.scan_done))
      else $error("decision without a finished scan");

endmodule
